// ----- src/bcdrtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcdrtc_pkg: shared constants and calendar tables
// Field widths, epoch constants and month tables for the BCD clock
// snapshot to epoch seconds converter.
// ----------------------------------------------------------------------------
package bcdrtc_pkg;

  localparam int unsigned EPOCH_W = 38;
  localparam int unsigned DAYS_W  = 22;
  localparam int unsigned TOD_W   = 17;

  localparam logic [14:0] EPOCH_YEAR         = 15'd1970;
  // Gregorian leap years in 1..1969
  localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [3:0]  BCD_MAX            = 4'd9;
  localparam logic [3:0]  MONTH_FEB          = 4'd2;

  // Days in a common year before the first of the month
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Month length in a common year
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] l;
    case (mon)
      4'd2:    l = 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// ----- src/bcd_rtc_to_epoch_seconds.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_rtc_to_epoch_seconds: BCD clock snapshot to seconds since 1970
// One beat on the in_ channel carries a full snapshot of the raw clock
// registers (year, month, day, hour, minute, second, all BCD). One beat on
// the out_ channel returns the seconds since 1970-01-01 00:00:00 and an
// error flag; on error the seconds are zero.
// The input register loads at the accepting edge, then the decode register (day
// count and time of day), then the result register, fed by the days-times-86400
// multiply.
// Throughput is one beat per cycle while out_stall is low; each stage refills
// in the cycle it empties, so in_stall rises only when all three stages hold
// data and the receiver stalls.
// While out_stall is high the result beat holds; upstream stages keep
// accepting until full.
// Reset (rst_n low, synchronous) empties all stages; the data registers are not reset.
// ----------------------------------------------------------------------------
module bcd_rtc_to_epoch_seconds
  import bcdrtc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [15:0]        in_year_bcd,
  input  wire logic [7:0]         in_month_reg,
  input  wire logic [7:0]         in_day_reg,
  input  wire logic [7:0]         in_hour_reg,
  input  wire logic [7:0]         in_minute_reg,
  input  wire logic [7:0]         in_second_reg,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [EPOCH_W-1:0] out_epoch_seconds,
  output      logic               out_range_error
);

  // Flow control
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic s1_adv, s2_adv, out_adv;

  assign out_adv  = !out_vld_r || !out_stall;
  assign s2_adv   = !s2_vld_r || out_adv;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_stall = !s1_adv;

  // Input register
  logic [15:0] s1_year_r;
  logic [7:0]  s1_month_r, s1_day_r, s1_hour_r, s1_min_r, s1_sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_year_r  <= in_year_bcd;
      s1_month_r <= in_month_reg;
      s1_day_r   <= in_day_reg;
      s1_hour_r  <= in_hour_reg;
      s1_min_r   <= in_minute_reg;
      s1_sec_r   <= in_second_reg;
    end
  end

  // Decode stage
  logic [3:0]  yd3, yd2, yd1, yd0;
  logic [7:0]  cent, yy;
  logic [14:0] year_bin;
  logic        leap, year_ok;
  logic [4:0]  mon5;
  logic [3:0]  mon;
  logic        mon_ok;
  logic [5:0]  day_val;
  logic [4:0]  mlen;
  logic        day_ok;
  logic [7:0]  hour_val, min_val, sec_val;
  logic        hour_ok, min_ok, sec_ok;
  logic        err_nxt;
  logic [8:0]  doy;
  logic [12:0] yoff;
  logic [11:0] leaps;
  logic [DAYS_W-1:0] days_nxt;
  logic [TOD_W-1:0]  tod_nxt;

  assign yd3 = s1_year_r[15:12];
  assign yd2 = s1_year_r[11:8];
  assign yd1 = s1_year_r[7:4];
  assign yd0 = s1_year_r[3:0];

  assign cent     = 8'(yd3) * 8'd10 + 8'(yd2);
  assign yy       = 8'(yd1) * 8'd10 + 8'(yd0);
  assign year_bin = 15'(cent) * 15'd100 + 15'(yy);
  // Century years are leap only when the century is a multiple of four
  assign leap     = (yy != 8'd0) ? (yy[1:0] == 2'd0) : (cent[1:0] == 2'd0);
  assign year_ok  = (yd3 <= BCD_MAX) && (yd2 <= BCD_MAX) && (yd1 <= BCD_MAX) &&
                    (yd0 <= BCD_MAX) && (year_bin >= EPOCH_YEAR);

  assign mon5   = (s1_month_r[4] ? 5'd10 : 5'd0) + 5'(s1_month_r[3:0]);
  assign mon    = mon5[3:0];
  assign mon_ok = (s1_month_r[3:0] <= BCD_MAX) && (mon5 >= 5'd1) && (mon5 <= 5'd12);

  assign day_val = 6'(s1_day_r[5:4]) * 6'd10 + 6'(s1_day_r[3:0]);
  assign mlen    = month_len(mon) + 5'((leap && (mon == MONTH_FEB)) ? 1 : 0);
  assign day_ok  = (s1_day_r[3:0] <= BCD_MAX) && (day_val >= 6'd1) &&
                   (day_val <= 6'(mlen));

  assign hour_val = 8'(s1_hour_r[7:4]) * 8'd10 + 8'(s1_hour_r[3:0]);
  assign min_val  = 8'(s1_min_r[7:4]) * 8'd10 + 8'(s1_min_r[3:0]);
  assign sec_val  = 8'(s1_sec_r[7:4]) * 8'd10 + 8'(s1_sec_r[3:0]);
  assign hour_ok  = (s1_hour_r[7:4] <= BCD_MAX) && (s1_hour_r[3:0] <= BCD_MAX) &&
                    (hour_val <= 8'd23);
  assign min_ok   = (s1_min_r[7:4] <= BCD_MAX) && (s1_min_r[3:0] <= BCD_MAX) &&
                    (min_val <= 8'd59);
  assign sec_ok   = (s1_sec_r[7:4] <= BCD_MAX) && (s1_sec_r[3:0] <= BCD_MAX) &&
                    (sec_val <= 8'd59);

  assign err_nxt = !(year_ok && mon_ok && day_ok && hour_ok && min_ok && sec_ok);

  assign doy  = cum_days(mon) + 9'((leap && (mon > MONTH_FEB)) ? 1 : 0) +
                9'(day_val) - 9'd1;
  assign yoff = 13'(year_bin - EPOCH_YEAR);
  // Leap days in 1970..year-1: 24*century + yy/4 + century/4, less this year's own and those before 1970
  assign leaps = 12'(cent) * 12'd24 + 12'(yy[7:2]) + 12'(cent[7:2]) -
                 12'(leap) - LEAPS_BEFORE_EPOCH;

  always_comb begin
    days_nxt = 22'(yoff) * 22'(DAYS_PER_YEAR) + 22'(leaps) + 22'(doy);
    tod_nxt  = 17'(hour_val[4:0]) * 17'd3600 + 17'(min_val[5:0]) * 17'd60 +
               17'(sec_val[5:0]);
    // Zero the operands on error so the product is zero too
    if (err_nxt) begin
      days_nxt = '0;
      tod_nxt  = '0;
    end
  end

  logic              s2_err_r;
  logic [DAYS_W-1:0] s2_days_r;
  logic [TOD_W-1:0]  s2_tod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_adv) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_adv && s1_vld_r) begin
      s2_err_r  <= err_nxt;
      s2_days_r <= days_nxt;
      s2_tod_r  <= tod_nxt;
    end
  end

  // Result stage
  logic [EPOCH_W-1:0] prod;
  logic [EPOCH_W-1:0] epoch_nxt;
  logic [EPOCH_W-1:0] epoch_r;
  logic               err_r;

  assign prod      = EPOCH_W'(s2_days_r) * EPOCH_W'(SECS_PER_DAY);
  assign epoch_nxt = prod + EPOCH_W'(s2_tod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s2_vld_r;
    end
    if (out_adv && s2_vld_r) begin
      epoch_r <= epoch_nxt;
      err_r   <= s2_err_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_epoch_seconds = epoch_r;
  assign out_range_error   = err_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_epoch_seconds == '0))
    else $error("error beat carries non-zero seconds");

  a_max_secs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |-> (out_epoch_seconds <= 38'd253402300799))
    else $error("seconds beyond 9999-12-31 23:59:59");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s2_vld_r && out_vld_r && out_stall))
    else $error("input stalled with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_vld_r && !s2_vld_r))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
